[src/etss_pkg.sv]
// ----------------------------------------------------------------------------
// etss_pkg
// Shared types, constants and the seven-segment decode for the elapsed-time
// display.
// ----------------------------------------------------------------------------
package etss_pkg;

  localparam int unsigned SegW      = 7;
  localparam int unsigned HoldW     = 4;
  localparam int unsigned RunW      = 5;
  localparam int unsigned HourW     = 5;

  localparam logic [3:0]       BlankCode = 4'd10;
  localparam logic [RunW-1:0]  RunMax    = 5'd31;
  localparam logic [HoldW-1:0] HoldReset = 4'd5;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_TICK   = 1'b1
  } req_type_t;

  typedef struct packed {
    logic [3:0] sec_ones;
    logic [2:0] sec_tens;
    logic [3:0] min_ones;
    logic [2:0] min_tens;
    logic [3:0] hour_digit;
    logic       one_shown;
    logic       minutes_mode;
  } disp_state_t;

  localparam disp_state_t DispReset = '{
    sec_ones:     4'd0,
    sec_tens:     3'd0,
    min_ones:     4'd0,
    min_tens:     3'd0,
    hour_digit:   BlankCode,
    one_shown:    1'b0,
    minutes_mode: 1'b0
  };

  typedef struct packed {
    logic [SegW-1:0] seg_units;
    logic [SegW-1:0] seg_tens;
    logic [SegW-1:0] seg_hours;
    logic            leading_one;
    logic            colon_on;
  } disp_word_t;

  // bit6 = a ... bit0 = g; codes above blank show nothing
  function automatic logic [SegW-1:0] seg_of(input logic [3:0] code);
    logic [SegW-1:0] seg;
    unique case (code)
      4'd0:    seg = 7'b1111110;
      4'd1:    seg = 7'b0110000;
      4'd2:    seg = 7'b1101101;
      4'd3:    seg = 7'b1111001;
      4'd4:    seg = 7'b0110011;
      4'd5:    seg = 7'b1011011;
      4'd6:    seg = 7'b1011111;
      4'd7:    seg = 7'b1110000;
      4'd8:    seg = 7'b1111111;
      4'd9:    seg = 7'b1111011;
      default: seg = 7'b0000000;
    endcase
    return seg;
  endfunction

endpackage

[src/etss_display.sv]
// ----------------------------------------------------------------------------
// etss_display
// Selects seconds or minutes for the two right digits and decodes all digits
// to segment patterns.
// ----------------------------------------------------------------------------
module etss_display (
  input  etss_pkg::disp_state_t st,
  output etss_pkg::disp_word_t  word
);
  import etss_pkg::*;

  logic [3:0] units_code;
  logic [3:0] tens_code;

  always_comb begin
    if (st.minutes_mode) begin
      units_code = st.min_ones;
      tens_code  = {1'b0, st.min_tens};
    end else begin
      units_code = st.sec_ones;
      tens_code  = {1'b0, st.sec_tens};
    end
  end

  always_comb begin
    word.seg_units   = seg_of(units_code);
    word.seg_tens    = seg_of(tens_code);
    word.seg_hours   = seg_of(st.hour_digit);
    word.leading_one = st.one_shown;
    word.colon_on    = st.minutes_mode;
  end

endmodule

[src/elapsed_time_seven_segment.sv]
// ----------------------------------------------------------------------------
// elapsed_time_seven_segment
// Stopwatch counting to 19:59:59 on a three-and-a-half digit display, cleared
// by a held button.
// Result: a word's display result is valid in the cycle after it is accepted.
// Throughput: one word per cycle unless out_ready stalls; result frees as taken.
// Reset: synchronous, active low; counters zero, hours blank, hold time 5.
// ----------------------------------------------------------------------------
module elapsed_time_seven_segment (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [etss_pkg::HoldW-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_req_type,
  input  logic                        in_button_level,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [etss_pkg::SegW-1:0]   out_seg_units,
  output logic [etss_pkg::SegW-1:0]   out_seg_tens,
  output logic [etss_pkg::SegW-1:0]   out_seg_hours,
  output logic                        out_leading_one,
  output logic                        out_colon_on
);
  import etss_pkg::*;

  logic [HoldW-1:0] reset_hold_r;
  disp_state_t      st_r, st_nxt;
  logic [HourW-1:0] hour_r, hour_nxt;
  logic [RunW-1:0]  low_run_r, low_run_nxt;
  logic             out_valid_r;
  disp_word_t       word_nxt, word_r;
  logic             accept;
  logic             at_max;
  logic             clear;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign at_max = (hour_r == 5'd19) && (st_r.min_tens == 3'd5) &&
                  (st_r.min_ones == 4'd9) && (st_r.sec_tens == 3'd5) &&
                  (st_r.sec_ones == 4'd9);

  always_comb begin
    st_nxt      = st_r;
    hour_nxt    = hour_r;
    low_run_nxt = low_run_r;
    clear       = 1'b0;
    unique case (req_type_t'(in_req_type))
      REQ_TICK: begin
        if (!at_max) begin
          if (st_r.sec_ones != 4'd9) begin
            st_nxt.sec_ones = st_r.sec_ones + 4'd1;
          end else begin
            st_nxt.sec_ones = 4'd0;
            if (st_r.sec_tens != 3'd5) begin
              st_nxt.sec_tens = st_r.sec_tens + 3'd1;
            end else begin
              st_nxt.sec_tens = 3'd0;
              if (st_r.min_ones != 4'd9) begin
                st_nxt.min_ones = st_r.min_ones + 4'd1;
              end else begin
                st_nxt.min_ones = 4'd0;
                if (st_r.min_tens != 3'd5) begin
                  st_nxt.min_tens = st_r.min_tens + 3'd1;
                end else begin
                  st_nxt.min_tens = 3'd0;
                  hour_nxt        = hour_r + 5'd1;
                end
              end
            end
          end
        end
        if (st_nxt.min_ones == 4'd1) begin
          st_nxt.minutes_mode = 1'b1;
        end
        if (st_nxt.minutes_mode) begin
          if (hour_nxt < 5'd10) begin
            st_nxt.hour_digit = hour_nxt[3:0];
          end else begin
            st_nxt.one_shown  = 1'b1;
            st_nxt.hour_digit = 4'(hour_nxt - 5'd10);
          end
        end
      end
      REQ_SAMPLE: begin
        if (in_button_level) begin
          low_run_nxt = '0;
        end else if (low_run_r != RunMax) begin
          low_run_nxt = low_run_r + 5'd1;
        end
        clear = low_run_nxt > {1'b0, reset_hold_r};
        if (clear) begin
          st_nxt   = '0;
          st_nxt.hour_digit = BlankCode;
          hour_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  etss_display u_display (
    .st   (st_nxt),
    .word (word_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_hold_r <= HoldReset;
    end else if (cfg_wr_en) begin
      reset_hold_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= DispReset;
      hour_r    <= '0;
      low_run_r <= '0;
    end else if (accept) begin
      st_r      <= st_nxt;
      hour_r    <= hour_nxt;
      low_run_r <= low_run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_seg_units   = word_r.seg_units;
  assign out_seg_tens    = word_r.seg_tens;
  assign out_seg_hours   = word_r.seg_hours;
  assign out_leading_one = word_r.leading_one;
  assign out_colon_on    = word_r.colon_on;

endmodule

[src/etss_checker.sv]
// ----------------------------------------------------------------------------
// etss_checker
// Port-level checks on the elapsed-time display, bound to the top level.
// ----------------------------------------------------------------------------
module etss_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [etss_pkg::SegW-1:0]  out_seg_units,
  input logic [etss_pkg::SegW-1:0]  out_seg_tens,
  input logic [etss_pkg::SegW-1:0]  out_seg_hours,
  input logic                       out_leading_one,
  input logic                       out_colon_on
);
  import etss_pkg::*;

  a_accept_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");

  a_seconds_mode_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_colon_on |-> !out_leading_one && (out_seg_hours == '0))
    else $error("hours shown outside minutes mode");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_seg_units) && $stable(out_seg_tens))
    else $error("stalled result changed");

endmodule

bind elapsed_time_seven_segment etss_checker u_etss_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_seg_units   (out_seg_units),
  .out_seg_tens    (out_seg_tens),
  .out_seg_hours   (out_seg_hours),
  .out_leading_one (out_leading_one),
  .out_colon_on    (out_colon_on)
);

[tb/elapsed_time_seven_segment_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// elapsed_time_seven_segment_test
// Self-checking bench for the stopwatch display: a short stimulus table, a
// hold-off that fills the block, random tick and button traffic under several
// hold times, and a press run long enough to saturate the button counter.
// Every display word is compared field by field with a table entry or a local
// model of the counters.
// ----------------------------------------------------------------------------
module elapsed_time_seven_segment_test;
  import etss_pkg::*;

  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned HoldOffCycles = 200;
  localparam int unsigned TailCycles    = 4;

  // index 0 at the right, blank at index 10
  localparam logic [10:0][SegW-1:0] GlyphOf = {
    7'h00, 7'h7B, 7'h7F, 7'h70, 7'h5F, 7'h5B, 7'h33, 7'h79, 7'h6D, 7'h30, 7'h7E
  };

  typedef struct packed {
    req_type_t  kind;
    logic       level;
    logic [3:0] repeats;
    logic       typed;
    disp_word_t word;
  } script_row_t;

  localparam int ScriptRows = 13;
  localparam script_row_t Script [ScriptRows] = '{
    '{REQ_SAMPLE, 1'b1, 4'd1, 1'b1, {7'h7E, 7'h7E, 7'h00, 1'b0, 1'b0}},
    '{REQ_TICK,   1'b1, 4'd1, 1'b1, {7'h30, 7'h7E, 7'h00, 1'b0, 1'b0}},
    '{REQ_TICK,   1'b1, 4'd8, 1'b1, {7'h7B, 7'h7E, 7'h00, 1'b0, 1'b0}},
    '{REQ_TICK,   1'b0, 4'd1, 1'b1, {7'h7E, 7'h30, 7'h00, 1'b0, 1'b0}},
    '{REQ_SAMPLE, 1'b0, 4'd5, 1'b1, {7'h7E, 7'h30, 7'h00, 1'b0, 1'b0}},
    '{REQ_SAMPLE, 1'b0, 4'd1, 1'b1, {7'h7E, 7'h7E, 7'h00, 1'b0, 1'b0}},
    '{REQ_TICK,   1'b1, 4'd1, 1'b1, {7'h30, 7'h7E, 7'h00, 1'b0, 1'b0}},
    '{REQ_SAMPLE, 1'b0, 4'd1, 1'b1, {7'h7E, 7'h7E, 7'h00, 1'b0, 1'b0}},
    '{REQ_SAMPLE, 1'b1, 4'd1, 1'b1, {7'h7E, 7'h7E, 7'h00, 1'b0, 1'b0}},
    '{REQ_TICK,   1'b0, 4'd3, 1'b0, '0},
    '{REQ_SAMPLE, 1'b0, 4'd2, 1'b0, '0},
    '{REQ_SAMPLE, 1'b1, 4'd1, 1'b0, '0},
    '{REQ_TICK,   1'b1, 4'd1, 1'b0, '0}
  };

  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 cfg_wr_en       = 1'b0;
  logic [HoldW-1:0]     cfg_wr_data     = '0;
  logic                 in_valid        = 1'b0;
  logic                 in_ready;
  req_type_t            in_req_type     = REQ_SAMPLE;
  logic                 in_button_level = 1'b1;
  logic                 out_valid;
  logic                 out_ready       = 1'b0;
  logic [SegW-1:0]      out_seg_units;
  logic [SegW-1:0]      out_seg_tens;
  logic [SegW-1:0]      out_seg_hours;
  logic                 out_leading_one;
  logic                 out_colon_on;

  // stopwatch model
  logic [3:0]           sec_lo;
  logic [2:0]           sec_hi;
  logic [3:0]           min_lo;
  logic [2:0]           min_hi;
  logic [HourW-1:0]     hours;
  logic [3:0]           hour_code;
  logic                 half_digit;
  logic                 minute_view;
  logic [RunW-1:0]      press_run;
  logic [HoldW-1:0]     hold_limit;

  disp_word_t           due_display [$];
  disp_word_t           due;
  int unsigned          mismatches   = 0;
  int unsigned          quiet_cycles = 0;
  bit                   calm         = 1'b0;
  bit                   hold_off     = 1'b0;

  always #2 clk = ~clk;

  elapsed_time_seven_segment i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_button_level (in_button_level),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_seg_units   (out_seg_units),
    .out_seg_tens    (out_seg_tens),
    .out_seg_hours   (out_seg_hours),
    .out_leading_one (out_leading_one),
    .out_colon_on    (out_colon_on)
  );

  function automatic logic [SegW-1:0] glyph(input logic [3:0] code);
    return (code > BlankCode) ? '0 : GlyphOf[code];
  endfunction

  function automatic void clear_stopwatch();
    sec_lo      = '0;
    sec_hi      = '0;
    min_lo      = '0;
    min_hi      = '0;
    hours       = '0;
    hour_code   = BlankCode;
    half_digit  = 1'b0;
    minute_view = 1'b0;
  endfunction

  function automatic disp_word_t stopwatch_step(input req_type_t kind, input logic level);
    disp_word_t shown;
    if (kind == REQ_TICK) begin
      sec_lo = sec_lo + 4'd1;
      if (sec_lo == 4'd10) begin
        sec_lo = '0;
        sec_hi = sec_hi + 3'd1;
        if (sec_hi == 3'd6) begin
          sec_hi = '0;
          min_lo = min_lo + 4'd1;
          if (min_lo == 4'd10) begin
            min_lo = '0;
            min_hi = min_hi + 3'd1;
            if (min_hi == 3'd6) begin
              min_hi = '0;
              hours  = hours + 5'd1;
              // hold at 19:59:59
              if (hours == 5'd20) begin
                hours  = 5'd19;
                min_hi = 3'd5;
                min_lo = 4'd9;
                sec_hi = 3'd5;
                sec_lo = 4'd9;
              end
            end
          end
        end
      end
      if (!minute_view && min_lo == 4'd1) minute_view = 1'b1;
      if (minute_view) begin
        if (hours < 5'd10) begin
          hour_code = hours[3:0];
        end else begin
          half_digit = 1'b1;
          hour_code  = 4'(hours - 5'd10);
        end
      end
    end else begin
      if (level) begin
        press_run = '0;
      end else if (press_run != RunMax) begin
        press_run = press_run + 5'd1;
      end
      if (press_run > RunW'(hold_limit)) clear_stopwatch();
    end
    shown.seg_units   = glyph(minute_view ? min_lo : sec_lo);
    shown.seg_tens    = glyph(minute_view ? {1'b0, min_hi} : {1'b0, sec_hi});
    shown.seg_hours   = glyph(hour_code);
    shown.leading_one = half_digit;
    shown.colon_on    = minute_view;
    return shown;
  endfunction

  function automatic int unsigned pause_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(input req_type_t kind, input logic level, input bit typed,
                           input disp_word_t typed_word);
    int unsigned gap;
    disp_word_t  predicted;
    gap = calm ? 0 : pause_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= kind;
    in_button_level <= level;
    do @(posedge clk); while (!in_ready);
    predicted = stopwatch_step(kind, level);
    due_display.push_back(typed ? typed_word : predicted);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_display.size() != 0);
  endtask

  task automatic set_hold(input logic [HoldW-1:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    hold_limit = value;
  endtask

  task automatic random_traffic(input int unsigned target);
    int unsigned sent;
    int unsigned len;
    int unsigned shape;
    sent = 0;
    while (sent < target) begin
      shape = $urandom_range(0, 9);
      if (shape < 4) begin
        // tick runs, now and then long enough to reach minutes
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 130) : $urandom_range(1, 12);
        repeat (len) send_word(REQ_TICK, $urandom_range(0, 1) != 0, 1'b0, '0);
      end else if (shape < 7) begin
        // press around the hold time, then release
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                          : int'(hold_limit) + $urandom_range(0, 2);
        repeat (len) send_word(REQ_SAMPLE, 1'b0, 1'b0, '0);
        send_word(REQ_SAMPLE, 1'b1, 1'b0, '0);
        len++;
      end else if (shape < 9) begin
        len = $urandom_range(1, 6);
        repeat (len) send_word(req_type_t'($urandom_range(0, 1)),
                               $urandom_range(0, 1) != 0, 1'b0, '0);
      end else begin
        // press run broken up by ticks
        len = $urandom_range(2, 20);
        repeat (len) send_word(($urandom_range(0, 2) == 0) ? REQ_TICK : REQ_SAMPLE,
                               1'b0, 1'b0, '0);
      end
      sent += len;
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_display.size() == 0) begin
        $display("%0t: display word with none due", $time);
        mismatches++;
      end else begin
        due = due_display.pop_front();
        check_field("seg_units", due.seg_units, out_seg_units);
        check_field("seg_tens", due.seg_tens, out_seg_tens);
        check_field("seg_hours", due.seg_hours, out_seg_hours);
        check_field("leading_one", due.leading_one, out_leading_one);
        check_field("colon_on", due.colon_on, out_colon_on);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : drain
    int unsigned span;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        span = calm ? 0 : pause_len();
        if (span != 0) begin
          out_ready <= 1'b0;
          repeat (span) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    hold_limit = HoldReset;
    press_run  = '0;
    clear_stopwatch();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int row = 0; row < ScriptRows; row++) begin
      for (int n = 1; n <= int'(Script[row].repeats); n++) begin
        send_word(Script[row].kind, Script[row].level,
                  Script[row].typed && n == int'(Script[row].repeats), Script[row].word);
      end
    end

    // hold off the receiver while words keep coming, then let it drain
    hold_off = 1'b1;
    random_traffic(40);
    wait_drained();

    set_hold('0);
    random_traffic(80);

    set_hold('1);
    random_traffic(80);
    // saturate the press counter, then prove it still reads as held
    repeat (32) send_word(REQ_SAMPLE, 1'b0, 1'b0, '0);
    send_word(REQ_TICK, 1'b1, 1'b0, '0);
    send_word(REQ_SAMPLE, 1'b0, 1'b0, '0);

    set_hold(HoldW'($urandom_range(1, 14)));
    random_traffic(80);

    set_hold(HoldReset);
    calm = 1'b1;
    random_traffic(40);
    calm = 1'b0;
    random_traffic(40);

    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0 && due_display.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
src/etss_pkg.sv
src/etss_display.sv
src/elapsed_time_seven_segment.sv
src/etss_checker.sv
tb/elapsed_time_seven_segment_test.sv
